// ----- rtl/core/sqt_pkg.sv -----
// Shared types and constants of the step sequencer.
`default_nettype none

package sqt_pkg;

  // Input word kinds, carried on the slave tuser.
  typedef enum logic [1:0] {
    KIND_TICK  = 2'd0,
    KIND_BLOCK = 2'd1,
    KIND_WRITE = 2'd2
  } kind_e;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    CFG_PITCH_OFFSET = 2'd0,
    CFG_GATE_TIME    = 2'd1,
    CFG_SEQ_LENGTH   = 2'd2
  } cfg_reg_e;

  localparam logic [5:0] HOLDOFF_BLOCKS = 6'd32;
  localparam logic [6:0] PITCH_MAX      = 7'd127;
  localparam logic [2:0] SUBTICKS       = 3'd4;

  typedef struct packed {
    logic [5:0] pitch_offset;
    logic [1:0] gate_time;
    logic [5:0] seq_length;
  } cfg_t;

  typedef struct packed {
    logic [6:0] pitch;
    logic       gate;
    logic [6:0] velocity;
  } step_entry_t;

  localparam step_entry_t STEP_RESET = '{pitch: 7'd31, gate: 1'b0, velocity: 7'd63};

  typedef struct packed {
    logic       gate;
    logic [3:0] voice;
    logic [6:0] pitch;
    logic [6:0] velocity;
    logic       start;
  } result_t;

endpackage

`default_nettype wire

// ----- rtl/core/sqt_table.sv -----
// Step table memory with per-entry valid bits and a prefetched, registered read.
`default_nettype none

module sqt_table #(
  parameter int unsigned DEPTH = 32,
  localparam int unsigned AW = $clog2(DEPTH)
) (
  input  wire                       clk_i,
  input  wire                       rst_ni,
  input  wire                       we_i,
  input  wire  [AW-1:0]             waddr_i,
  input  sqt_pkg::step_entry_t      wdata_i,
  input  wire  [AW-1:0]             raddr_i,
  output sqt_pkg::step_entry_t      rdata_o
);
  import sqt_pkg::*;

  step_entry_t      mem [DEPTH];
  logic [DEPTH-1:0] vld_q;
  step_entry_t      rd_q;
  logic             rd_vld_q;
  logic             byp_q;
  step_entry_t      byp_data_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_q       <= mem[raddr_i];
    byp_data_q <= wdata_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
      byp_q    <= 1'b0;
    end else begin
      if (we_i) begin
        vld_q[waddr_i] <= 1'b1;
      end
      rd_vld_q <= vld_q[raddr_i];
      byp_q    <= we_i && (waddr_i == raddr_i);
    end
  end

  // A write landing on the address being read wins over the stale array data.
  assign rdata_o = byp_q ? byp_data_q : (rd_vld_q ? rd_q : STEP_RESET);

endmodule

`default_nettype wire

// ----- rtl/core/sqt_ctrl.sv -----
// Sequencer state: position, subtick phase, restart holdoff and held outputs.
`default_nettype none

module sqt_ctrl #(
  parameter int unsigned MAX_STEPS = 32,
  parameter int unsigned VOICES    = 16,
  localparam int unsigned AW = $clog2(MAX_STEPS)
) (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  wire                   valid_i,
  input  wire  [1:0]            kind_i,
  input  wire                   trigger_i,
  input  wire                   voice_found_i,
  input  wire  [3:0]            voice_index_i,
  input  wire  [4:0]            step_index_i,
  input  wire  [6:0]            step_pitch_i,
  input  wire                   step_gate_i,
  input  wire  [6:0]            step_velocity_i,
  input  sqt_pkg::cfg_t         cfg_i,
  input  sqt_pkg::step_entry_t  step_i,
  output logic [AW-1:0]         raddr_o,
  output logic                  we_o,
  output logic [AW-1:0]         waddr_o,
  output sqt_pkg::step_entry_t  wdata_o,
  output sqt_pkg::result_t      held_d_o
);
  import sqt_pkg::*;

  logic [AW-1:0] pos_q, pos_d, pos_cur;
  logic [1:0]    sub_q, sub_d, sub_cur;
  logic          restart_q, restart_d;
  logic [5:0]    holdoff_q, holdoff_d;
  result_t       held_q, held_d;
  logic [6:0]    wrap_len;
  logic [6:0]    pos_inc;
  logic [7:0]    pitch_sum;
  logic          voice_ok;
  logic [2:0]    drop_at;

  always_comb begin
    wrap_len  = ({1'b0, cfg_i.seq_length} > 7'(MAX_STEPS)) ? 7'(MAX_STEPS)
                                                           : {1'b0, cfg_i.seq_length};
    // A pending restart takes effect at the start of the next tick.
    pos_cur   = restart_q ? '0 : pos_q;
    sub_cur   = restart_q ? 2'd0 : sub_q;
    pos_inc   = 7'(pos_cur) + 7'd1;
    pitch_sum = {1'b0, step_i.pitch} + {2'b00, cfg_i.pitch_offset};
    voice_ok  = voice_found_i && ({3'b000, voice_index_i} < 7'(VOICES));
    drop_at   = SUBTICKS - {1'b0, cfg_i.gate_time};

    pos_d     = pos_q;
    sub_d     = sub_q;
    restart_d = restart_q;
    holdoff_d = holdoff_q;
    held_d    = held_q;
    we_o      = 1'b0;

    if (valid_i) begin
      unique case (kind_i)
        KIND_TICK: begin
          restart_d    = 1'b0;
          pos_d        = pos_cur;
          held_d.start = (pos_cur == '0);
          if (sub_cur == 2'd0) begin
            held_d.pitch    = (pitch_sum > {1'b0, PITCH_MAX}) ? PITCH_MAX : pitch_sum[6:0];
            held_d.voice    = voice_ok ? voice_index_i : 4'd0;
            held_d.gate     = voice_ok && step_i.gate;
            held_d.velocity = step_i.velocity;
            pos_d           = (pos_inc >= wrap_len) ? '0 : pos_inc[AW-1:0];
          end
          if ({1'b0, sub_cur} == drop_at) begin
            held_d.gate = 1'b0;
          end
          sub_d = sub_cur + 2'd1;
        end
        KIND_BLOCK: begin
          if (holdoff_q != 6'd0) begin
            holdoff_d = holdoff_q - 6'd1;
          end else if (!restart_q && trigger_i) begin
            restart_d = 1'b1;
            holdoff_d = HOLDOFF_BLOCKS;
          end
        end
        KIND_WRITE: begin
          we_o = ({2'b00, step_index_i} < 7'(MAX_STEPS));
        end
        default: begin
        end
      endcase
    end

    // Prefetch the entry the next tick will use.
    raddr_o = restart_d ? '0 : pos_d;
    waddr_o = AW'({2'b00, step_index_i});
    wdata_o = '{pitch: step_pitch_i, gate: step_gate_i, velocity: step_velocity_i};
  end

  assign held_d_o = held_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q     <= '0;
      sub_q     <= 2'd0;
      restart_q <= 1'b0;
      holdoff_q <= 6'd0;
      held_q    <= '0;
    end else begin
      pos_q     <= pos_d;
      sub_q     <= sub_d;
      restart_q <= restart_d;
      holdoff_q <= holdoff_d;
      held_q    <= held_d;
    end
  end

  a_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    7'(pos_q) < 7'(MAX_STEPS))
    else $error("position beyond table depth");

  a_holdoff_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    holdoff_q <= HOLDOFF_BLOCKS)
    else $error("holdoff counter above its load value");

  a_restart_tick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_i && kind_i == KIND_TICK && restart_q)
      |=> (held_q.start && sub_q == 2'd1 && !restart_q))
    else $error("restart did not return the sequence to its first step");

  a_arm: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_i && kind_i == KIND_BLOCK && !restart_q && holdoff_q == 6'd0 && trigger_i)
      |=> (restart_q && holdoff_q == HOLDOFF_BLOCKS))
    else $error("trigger did not arm a restart");

endmodule

`default_nettype wire

// ----- rtl/core/step_sequencer.sv -----
// Step sequencer top level: stream ports, configuration registers, result register.
//
//   Port group   Dir  Payload
//   s_axis_*     in   tuser = kind; tdata = trigger, voice and step-write fields
//   m_axis_*     out  tdata = gate, voice, pitch code, velocity, step start
//   cfg_*        in   register write: index and data, no read-back
//
// One word is accepted per clock; its result appears in the output register on
// the next cycle and the next word may be accepted in that same cycle.
// Ready drops only while a result sits unclaimed in the output register.
// The step entry is prefetched from the table into a register, addressed by
// the next position, so a tick finds its entry already registered.
// After reset every table entry reads its reset value through per-entry valid
// bits; no clearing pass is needed and words are accepted right away.
`default_nettype none

module step_sequencer #(
  parameter int unsigned MAX_STEPS = 32,
  parameter int unsigned VOICES    = 16
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         s_axis_tvalid,
  output logic        s_axis_tready,
  // [0] trigger_high, [1] voice_found, [5:2] voice_index, [10:6] step_index,
  // [17:11] step_pitch, [18] step_gate, [25:19] step_velocity, [31:26] zero
  input  wire  [31:0] s_axis_tdata,
  // [1:0] kind
  input  wire  [1:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  wire         m_axis_tready,
  // [0] gate_out, [4:1] voice_out, [11:5] pitch_code, [18:12] velocity_out,
  // [19] step_start, [23:20] zero
  output logic [23:0] m_axis_tdata,
  input  wire         cfg_we_i,
  input  wire  [1:0]  cfg_index_i,
  input  wire  [5:0]  cfg_data_i
);
  import sqt_pkg::*;

  localparam int unsigned AW = $clog2(MAX_STEPS);

  logic          accept;
  cfg_t          cfg_q;
  logic          m_valid_q;
  result_t       res_q;
  result_t       held_d;
  step_entry_t   rd_entry;
  step_entry_t   wr_entry;
  logic [AW-1:0] raddr;
  logic [AW-1:0] waddr;
  logic          tbl_we;

  // The output register decouples the two sides: a new word goes in while
  // the previous result is being taken.
  assign s_axis_tready = !m_valid_q || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;

  // Configuration registers. Writes to an index past the list are dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.pitch_offset <= 6'd32;
      cfg_q.gate_time    <= 2'd1;
      cfg_q.seq_length   <= 6'd16;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_PITCH_OFFSET: cfg_q.pitch_offset <= cfg_data_i;
        CFG_GATE_TIME:    cfg_q.gate_time    <= cfg_data_i[1:0];
        CFG_SEQ_LENGTH:   cfg_q.seq_length   <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  sqt_ctrl #(
    .MAX_STEPS (MAX_STEPS),
    .VOICES    (VOICES)
  ) u_ctrl (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .valid_i         (accept),
    .kind_i          (s_axis_tuser),
    .trigger_i       (s_axis_tdata[0]),
    .voice_found_i   (s_axis_tdata[1]),
    .voice_index_i   (s_axis_tdata[5:2]),
    .step_index_i    (s_axis_tdata[10:6]),
    .step_pitch_i    (s_axis_tdata[17:11]),
    .step_gate_i     (s_axis_tdata[18]),
    .step_velocity_i (s_axis_tdata[25:19]),
    .cfg_i           (cfg_q),
    .step_i          (rd_entry),
    .raddr_o         (raddr),
    .we_o            (tbl_we),
    .waddr_o         (waddr),
    .wdata_o         (wr_entry),
    .held_d_o        (held_d)
  );

  sqt_table #(
    .DEPTH (MAX_STEPS)
  ) u_table (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (tbl_we),
    .waddr_i (waddr),
    .wdata_i (wr_entry),
    .raddr_i (raddr),
    .rdata_o (rd_entry)
  );

  // Result register: every accepted word yields one result word showing the
  // held outputs after that word has been applied.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (accept) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      res_q <= held_d;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {4'b0000, res_q.start, res_q.velocity, res_q.pitch,
                          res_q.voice, res_q.gate};

endmodule

`default_nettype wire
